>>> hw/rtl/uvpt_pkg.sv
package uvpt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [5:0] {
        M_LEAD  = 6'b000001,
        M_SEG   = 6'b000010,
        M_TEXT  = 6'b000100,
        M_DOT1  = 6'b001000,
        M_DOT2  = 6'b010000,
        M_SLASH = 6'b100000
    } t_mode;

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_SLASH = 2'd1,
        SEP_COLON = 2'd2
    } t_sep;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [1:0]                  cnt;
        logic                        done;
    } t_entry;

endpackage

>>> hw/rtl/uvpt_front.sv
module uvpt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char,
    output logic            o_push,
    output uvpt_pkg::t_entry o_entry
);
    import uvpt_pkg::*;

    t_mode r_mode, n_mode;
    t_sep  r_sep, n_sep;
    logic  r_vol, n_vol;

    logic [MAX_RESULTS-1:0][7:0] outs;
    logic [1:0]                  n_cnt;
    logic                        ended;

    always_comb begin
        t_mode      m;
        t_sep       p;
        logic       v;
        logic [1:0] n;
        logic       taken;
        logic       fin;
        logic       is_slash;
        logic       is_colon;
        logic       is_dot;
        logic       is_nul;

        m        = r_mode;
        p        = r_sep;
        v        = r_vol;
        n        = 2'd0;
        taken    = 1'b0;
        fin      = 1'b0;
        outs     = '0;
        is_slash = (i_char == CH_SLASH);
        is_colon = (i_char == CH_COLON);
        is_dot   = (i_char == CH_DOT);
        is_nul   = (i_char == CH_NUL);

        for (int k = 0; k < 4; k++) begin
            if (!taken) begin
                case (m)
                    M_LEAD: begin
                        if (is_slash) begin
                            v     = 1'b1;
                            taken = 1'b1;
                        end else begin
                            m = M_SEG;
                        end
                    end
                    M_SEG: begin
                        if (is_dot) begin
                            m     = M_DOT1;
                            taken = 1'b1;
                        end else begin
                            m = M_TEXT;
                        end
                    end
                    M_TEXT: begin
                        if (is_slash) begin
                            p = SEP_SLASH;
                            m = M_SLASH;
                        end else if (is_colon) begin
                            p = SEP_COLON;
                            m = M_SLASH;
                        end else if (is_nul) begin
                            fin = 1'b1;
                        end else begin
                            outs[n] = i_char;
                            n       = n + 2'd1;
                        end
                        taken = 1'b1;
                    end
                    M_DOT1: begin
                        if (is_nul) begin
                            fin = 1'b1;
                        end else if (is_dot) begin
                            m = M_DOT2;
                        end else if (is_slash) begin
                            p = SEP_NONE;
                            m = M_SLASH;
                        end else begin
                            outs[n] = CH_DOT;
                            n       = n + 2'd1;
                            outs[n] = i_char;
                            n       = n + 2'd1;
                            m       = M_TEXT;
                        end
                        taken = 1'b1;
                    end
                    M_DOT2: begin
                        if (is_slash || is_nul) begin
                            p = SEP_SLASH;
                            m = M_SLASH;
                        end else begin
                            outs[n] = CH_DOT;
                            n       = n + 2'd1;
                            outs[n] = CH_DOT;
                            n       = n + 2'd1;
                            outs[n] = i_char;
                            n       = n + 2'd1;
                            m       = M_TEXT;
                            taken   = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (is_slash) begin
                            taken = 1'b1;
                        end else begin
                            if (v) begin
                                v = 1'b0;
                                p = SEP_COLON;
                            end
                            case (p)
                                SEP_SLASH: begin
                                    outs[n] = CH_SLASH;
                                    n       = n + 2'd1;
                                end
                                SEP_COLON: begin
                                    outs[n] = CH_COLON;
                                    n       = n + 2'd1;
                                end
                                default: begin
                                end
                            endcase
                            m = M_SEG;
                        end
                    end
                    default: begin
                        m = M_LEAD;
                    end
                endcase
            end
        end

        if (fin) begin
            if (v) begin
                outs[n] = CH_COLON;
                n       = n + 2'd1;
            end
            outs[n] = CH_NUL;
            n       = n + 2'd1;
            m       = M_LEAD;
            p       = SEP_NONE;
            v       = 1'b0;
        end

        n_mode = m;
        n_sep  = p;
        n_vol  = v;
        n_cnt  = n;
        ended  = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_LEAD;
            r_sep  <= SEP_NONE;
            r_vol  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_sep  <= n_sep;
            r_vol  <= n_vol;
        end
    end

    assign o_push        = i_accept && (n_cnt != 2'd0);
    assign o_entry.chars = outs;
    assign o_entry.cnt   = n_cnt;
    assign o_entry.done  = ended;

endmodule

>>> hw/rtl/uvpt_queue.sv
module uvpt_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  uvpt_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    output uvpt_pkg::t_entry o_head,
    input  logic             i_pop
);
    import uvpt_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/uvpt_back.sv
module uvpt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  uvpt_pkg::t_entry i_head,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,
    output logic             o_tlast,
    output logic             o_tuser
);
    import uvpt_pkg::*;

    logic       r_valid;
    t_entry     r_ent;
    logic [1:0] r_idx;
    logic       at_last;
    logic       load;

    assign at_last  = (r_idx == (r_ent.cnt - 2'd1));
    assign load     = i_valid && (!r_valid || (i_tready && at_last));
    assign o_pop    = load;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_ent.chars[r_idx];
    assign o_tlast  = at_last;
    assign o_tuser  = r_ent.done && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_tready) begin
            if (at_last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_head;
        end
    end

endmodule

>>> hw/rtl/unix_to_volume_path_translator.sv
// Translates a Unix-style path, one character per input word, into a volume-style path that
// leaves as a stream of output words, with tlast on the final word caused by each input and
// tuser on the terminating zero. Input words are accepted one per cycle while the queue is not
// full, which holds as long as each yields at most one output word and the output is ready; an
// input that yields two or three words (a kept dot prefix, a parent segment or the end of the
// path) keeps the output busy longer, and the queue of QUEUE_DEPTH translated entries between
// the front and back halves absorbs such bursts before the input is stalled. Inputs that yield
// nothing produce no word and queue no entry. The first word of an input is registered in the
// queue and then in the back half's entry register; earlier entries or output stalls delay it.
module unix_to_volume_path_translator #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] char_in
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] char_out
    output logic       o_m_axis_tlast,
    output logic       o_m_axis_tuser   // [0] path_done
);
    import uvpt_pkg::*;

    logic   in_accept;
    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry entry;
    t_entry head;

    assign o_s_axis_tready = !full;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    uvpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_s_axis_tdata),
        .o_push   (push),
        .o_entry  (entry)
    );

    uvpt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    uvpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast),
        .o_tuser  (o_m_axis_tuser)
    );

    // The terminator is always the final word of its input.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("path_done without tlast");

    // The terminating word carries a zero character.
    a_done_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == CH_NUL))
        else $error("terminator word is not zero");

    // An accepted end of path always queues a terminating entry.
    a_nul_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_s_axis_tdata == CH_NUL)) |-> (push && entry.done))
        else $error("end of path produced no terminator entry");

    // The back half only takes an entry that the queue holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
